@@ rtl/core/brc_pkg.sv @@
`timescale 1ns / 1ps
`default_nettype none

package brc_pkg;

   // curve geometry and number format
   localparam int CURVE_POINTS  = 101;
   localparam int FRACTION_BITS = 16;
   localparam int ADDR_W        = $clog2(CURVE_POINTS);

   // field widths
   localparam int CMD_W    = 2;
   localparam int INDEX_W  = 7;
   localparam int ENTRY_W  = 23;
   localparam int QUERY_W  = 24;
   localparam int STATUS_W = 2;

   // datapath widths
   localparam int DIFF_W    = ENTRY_W + 1;
   localparam int PROD_W    = ENTRY_W + FRACTION_BITS;
   localparam int QUOT_W    = FRACTION_BITS + 1;
   localparam int REM_W     = ENTRY_W + 2;
   localparam int DIV_CNT_W = $clog2(QUOT_W);

   localparam int ONE_Q      = 1 << FRACTION_BITS;
   localparam int MIN_STEP   = (ONE_Q + 19) / 20;
   localparam int MAX_STEP   = ONE_Q;
   localparam int BRIGHT_MAX = (CURVE_POINTS - 1) * ONE_Q;

   // operation codes
   localparam logic [CMD_W-1:0] OP_WRITE     = CMD_W'(0);
   localparam logic [CMD_W-1:0] OP_TO_COORD  = CMD_W'(1);
   localparam logic [CMD_W-1:0] OP_TO_BRIGHT = CMD_W'(2);
   localparam logic [CMD_W-1:0] OP_SLOPE     = CMD_W'(3);

   // result status codes
   localparam logic [STATUS_W-1:0] ST_OK     = STATUS_W'(0);
   localparam logic [STATUS_W-1:0] ST_REJECT = STATUS_W'(1);
   localparam logic [STATUS_W-1:0] ST_COMMIT = STATUS_W'(2);

   // curve read address select
   localparam int RD_SEL_W = 3;
   localparam logic [RD_SEL_W-1:0] RD_SEL_LOWER = RD_SEL_W'(0);
   localparam logic [RD_SEL_W-1:0] RD_SEL_UPPER = RD_SEL_W'(1);
   localparam logic [RD_SEL_W-1:0] RD_SEL_FIRST = RD_SEL_W'(2);
   localparam logic [RD_SEL_W-1:0] RD_SEL_LAST  = RD_SEL_W'(3);
   localparam logic [RD_SEL_W-1:0] RD_SEL_ONE   = RD_SEL_W'(4);
   localparam logic [RD_SEL_W-1:0] RD_SEL_NEXT  = RD_SEL_W'(5);

   typedef struct packed {
      logic [CMD_W-1:0]          command;
      logic [INDEX_W-1:0]        entry_index;
      logic [ENTRY_W-1:0]        entry_value;
      logic signed [QUERY_W-1:0] query_value;
   } brc_req_type;

   typedef struct packed {
      logic [ENTRY_W-1:0]  result_value;
      logic [STATUS_W-1:0] status;
      logic                calibrated;
   } brc_rsp_type;

   typedef struct packed {
      logic                load_item;
      logic                do_write;
      logic                rd_en;
      logic [RD_SEL_W-1:0] rd_sel;
      logic                cap_base;
      logic                do_diff;
      logic                do_mul;
      logic                do_clamp;
      logic                scan_step;
      logic                div_step;
      logic                do_result;
      logic                load_rsp;
   } brc_dp_cmd_type;

   typedef struct packed {
      logic [CMD_W-1:0] item_op;
      logic             scan_hit;
      logic             scan_last;
   } brc_dp_status_type;

endpackage

`default_nettype wire

@@ rtl/core/brc_datapath.sv @@
`timescale 1ns / 1ps
`default_nettype none

module brc_datapath (
   input  wire logic                       clock,
   input  wire logic                       reset,
   input  wire brc_pkg::brc_dp_cmd_type    cmd,
   output brc_pkg::brc_dp_status_type      status,
   input  wire brc_pkg::brc_req_type       req_payload,
   output brc_pkg::brc_rsp_type            rsp_payload
);
   import brc_pkg::*;

   localparam logic [ADDR_W-1:0]         LAST_ADDR    = ADDR_W'(CURVE_POINTS - 1);
   localparam logic [ADDR_W-1:0]         SLOPE_ADDR   = ADDR_W'(CURVE_POINTS - 2);
   localparam logic [INDEX_W-1:0]        LAST_INDEX   = INDEX_W'(CURVE_POINTS - 1);
   localparam logic [INDEX_W-1:0]        POINTS_INDEX = INDEX_W'(CURVE_POINTS);
   localparam logic signed [QUERY_W-1:0] BRIGHT_MAX_Q = QUERY_W'(BRIGHT_MAX);
   localparam logic signed [DIFF_W-1:0]  MIN_STEP_D   = DIFF_W'(MIN_STEP);
   localparam logic signed [DIFF_W-1:0]  MAX_STEP_D   = DIFF_W'(MAX_STEP);
   localparam int                        BINT_W       = ENTRY_W - FRACTION_BITS;

   // curve banks
   logic [ENTRY_W-1:0] bank_a_mem [CURVE_POINTS];
   logic [ENTRY_W-1:0] bank_b_mem [CURVE_POINTS];

   // latched item
   logic [CMD_W-1:0]          op_ff, op_in;
   logic [INDEX_W-1:0]        index_ff, index_in;
   logic [ENTRY_W-1:0]        value_ff, value_in;
   logic signed [QUERY_W-1:0] query_ff, query_in;

   // curve control state
   logic                    active_bank_ff, active_bank_in;
   logic                    calibrated_ff, calibrated_in;
   logic                    load_ff, load_in;
   logic [INDEX_W-1:0]      next_ff, next_in;
   logic [ENTRY_W-1:0]      prev_ff, prev_in;
   logic [CURVE_POINTS-1:0] valid_a_ff, valid_a_in;
   logic [STATUS_W-1:0]     wr_status_ff, wr_status_in;

   // read port
   logic [ADDR_W-1:0]  rd_addr;
   logic [ADDR_W-1:0]  rd_addr_ff;
   logic [ENTRY_W-1:0] bank_a_rd_ff;
   logic [ENTRY_W-1:0] bank_b_rd_ff;
   logic               valid_rd_ff;
   logic [ENTRY_W-1:0] rd_value;

   // arithmetic
   logic [ENTRY_W-1:0]       base_ff, base_in;
   logic signed [DIFF_W-1:0] diff_ff, diff_in;
   logic [PROD_W-1:0]        prod_ff, prod_in;
   logic [ENTRY_W-1:0]       coord_ff, coord_in;
   logic [ADDR_W-1:0]        lower_ff, lower_in;
   logic                     found_ff, found_in;
   logic                     skip_ff, skip_in;
   logic [REM_W-1:0]         rem_ff, rem_in;
   logic [ENTRY_W-1:0]       den_ff, den_in;
   logic [QUOT_W-1:0]        quot_ff, quot_in;
   logic [ENTRY_W-1:0]       res_ff, res_in;
   brc_rsp_type              rsp_ff, rsp_in;

   logic [ENTRY_W-1:0]       bright_clamped;
   logic [BINT_W-1:0]        bright_int;
   logic [FRACTION_BITS-1:0] bright_frac;
   logic [ADDR_W-1:0]        lower_addr;
   logic [ADDR_W-1:0]        upper_addr;
   logic [ENTRY_W-1:0]       last_eff;
   logic signed [DIFF_W-1:0] step;
   logic signed [DIFF_W-1:0] scan_width;
   logic signed [DIFF_W-1:0] scan_offset;
   logic                     wr_en;
   logic [ADDR_W-1:0]        wr_addr;
   logic [REM_W-1:0]         rem_sub;

   // brightness clamp and segment address
   always_comb begin
      if (query_ff < 0) begin
         bright_clamped = '0;
      end else if (query_ff > BRIGHT_MAX_Q) begin
         bright_clamped = ENTRY_W'(BRIGHT_MAX);
      end else begin
         bright_clamped = query_ff[ENTRY_W-1:0];
      end
      bright_int  = bright_clamped[ENTRY_W-1:FRACTION_BITS];
      bright_frac = bright_clamped[FRACTION_BITS-1:0];
      lower_addr  = ADDR_W'(bright_int);
      if (op_ff == OP_SLOPE && lower_addr > SLOPE_ADDR) begin
         lower_addr = SLOPE_ADDR;
      end
      upper_addr = (lower_addr == LAST_ADDR) ? LAST_ADDR : lower_addr + 1'b1;
   end

   always_comb begin
      unique case (cmd.rd_sel)
         RD_SEL_LOWER: rd_addr = lower_addr;
         RD_SEL_UPPER: rd_addr = upper_addr;
         RD_SEL_FIRST: rd_addr = '0;
         RD_SEL_LAST:  rd_addr = LAST_ADDR;
         RD_SEL_ONE:   rd_addr = ADDR_W'(1);
         RD_SEL_NEXT:  rd_addr = (rd_addr_ff == LAST_ADDR) ? LAST_ADDR : rd_addr_ff + 1'b1;
         default:      rd_addr = '0;
      endcase
   end

   // an entry of bank a never written since reset reads as the identity
   assign rd_value = active_bank_ff ? bank_b_rd_ff :
                     (valid_rd_ff ? bank_a_rd_ff : ENTRY_W'(rd_addr_ff) << FRACTION_BITS);

   // curve load
   always_comb begin
      active_bank_in = active_bank_ff;
      calibrated_in  = calibrated_ff;
      load_in        = load_ff;
      next_in        = next_ff;
      prev_in        = prev_ff;
      wr_status_in   = wr_status_ff;
      wr_en          = 1'b0;
      wr_addr        = ADDR_W'(index_ff);
      step           = $signed({1'b0, value_ff}) - $signed({1'b0, prev_ff});
      if (cmd.do_write) begin
         wr_status_in = ST_OK;
         if (index_ff == '0) begin
            if (value_ff != '0) begin
               load_in      = 1'b0;
               next_in      = '0;
               wr_status_in = ST_REJECT;
            end else begin
               wr_en   = 1'b1;
               prev_in = '0;
               load_in = 1'b1;
               next_in = INDEX_W'(1);
            end
         end else if (load_ff && index_ff == next_ff && index_ff < POINTS_INDEX
                      && step >= MIN_STEP_D && step <= MAX_STEP_D) begin
            wr_en   = 1'b1;
            prev_in = value_ff;
            next_in = index_ff + 1'b1;
            if (index_ff == LAST_INDEX) begin
               active_bank_in = ~active_bank_ff;
               calibrated_in  = 1'b1;
               load_in        = 1'b0;
               next_in        = '0;
               wr_status_in   = ST_COMMIT;
            end
         end else begin
            load_in      = 1'b0;
            next_in      = '0;
            wr_status_in = ST_REJECT;
         end
      end
      valid_a_in = valid_a_ff;
      if (wr_en && active_bank_ff) begin
         valid_a_in[wr_addr] = 1'b1;
      end
   end

   // query arithmetic
   always_comb begin
      op_in    = cmd.load_item ? req_payload.command     : op_ff;
      index_in = cmd.load_item ? req_payload.entry_index : index_ff;
      value_in = cmd.load_item ? req_payload.entry_value : value_ff;
      query_in = cmd.load_item ? req_payload.query_value : query_ff;

      last_eff    = (rd_value < base_ff) ? base_ff : rd_value;
      scan_width  = $signed({1'b0, rd_value}) - $signed({1'b0, base_ff});
      scan_offset = $signed({1'b0, coord_ff}) - $signed({1'b0, base_ff});

      base_in  = base_ff;
      diff_in  = diff_ff;
      prod_in  = prod_ff;
      coord_in = coord_ff;
      lower_in = lower_ff;
      found_in = cmd.load_item ? 1'b0 : found_ff;
      skip_in  = skip_ff;
      rem_in   = rem_ff;
      den_in   = den_ff;
      quot_in  = quot_ff;

      if (cmd.cap_base) begin
         base_in = rd_value;
      end
      if (cmd.do_diff) begin
         diff_in = scan_width;
      end
      if (cmd.do_mul) begin
         prod_in = PROD_W'(bright_frac) * PROD_W'(diff_ff[ENTRY_W-1:0]);
      end
      if (cmd.do_clamp) begin
         if (query_ff < $signed({1'b0, base_ff})) begin
            coord_in = base_ff;
         end else if (query_ff > $signed({1'b0, last_eff})) begin
            coord_in = last_eff;
         end else begin
            coord_in = query_ff[ENTRY_W-1:0];
         end
      end
      if (cmd.scan_step) begin
         if (status.scan_hit) begin
            // segment found: set up the fraction division
            lower_in = rd_addr_ff - 1'b1;
            found_in = 1'b1;
            skip_in  = (scan_width <= 0) || (coord_ff < base_ff);
            rem_in   = REM_W'(scan_offset[ENTRY_W-1:0]);
            den_in   = scan_width[ENTRY_W-1:0];
            quot_in  = '0;
         end else begin
            base_in = rd_value;
         end
      end
      rem_sub = rem_ff - REM_W'(den_ff);
      if (cmd.div_step) begin
         if (rem_ff >= REM_W'(den_ff)) begin
            rem_in  = rem_sub << 1;
            quot_in = {quot_ff[QUOT_W-2:0], 1'b1};
         end else begin
            rem_in  = rem_ff << 1;
            quot_in = {quot_ff[QUOT_W-2:0], 1'b0};
         end
      end
   end

   // result assembly
   always_comb begin
      res_in = res_ff;
      if (cmd.do_result) begin
         case (op_ff)
            OP_TO_COORD: begin
               res_in = diff_ff < 0 ? base_ff : base_ff + prod_ff[PROD_W-1:FRACTION_BITS];
            end
            OP_SLOPE: begin
               res_in = diff_ff < 0 ? '0 : diff_ff[ENTRY_W-1:0];
            end
            OP_TO_BRIGHT: begin
               if (!found_ff) begin
                  res_in = ENTRY_W'(BRIGHT_MAX);
               end else begin
                  res_in = ENTRY_W'({lower_ff, {FRACTION_BITS{1'b0}}})
                         + (skip_ff ? '0 : ENTRY_W'(quot_ff));
               end
            end
            default: res_in = '0;
         endcase
      end
      rsp_in = rsp_ff;
      if (cmd.load_rsp) begin
         rsp_in.result_value = res_ff;
         rsp_in.status       = (op_ff == OP_WRITE) ? wr_status_ff : ST_OK;
         rsp_in.calibrated   = calibrated_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en && active_bank_ff) begin
         bank_a_mem[wr_addr] <= value_ff;
      end
      if (wr_en && !active_bank_ff) begin
         bank_b_mem[wr_addr] <= value_ff;
      end
      if (cmd.rd_en) begin
         bank_a_rd_ff <= bank_a_mem[rd_addr];
         bank_b_rd_ff <= bank_b_mem[rd_addr];
         valid_rd_ff  <= valid_a_ff[rd_addr];
         rd_addr_ff   <= rd_addr;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         active_bank_ff <= 1'b0;
         calibrated_ff  <= 1'b0;
         load_ff        <= 1'b0;
         next_ff        <= '0;
         valid_a_ff     <= '0;
      end else begin
         active_bank_ff <= active_bank_in;
         calibrated_ff  <= calibrated_in;
         load_ff        <= load_in;
         next_ff        <= next_in;
         valid_a_ff     <= valid_a_in;
      end
   end

   always_ff @(posedge clock) begin
      op_ff        <= op_in;
      index_ff     <= index_in;
      value_ff     <= value_in;
      query_ff     <= query_in;
      prev_ff      <= prev_in;
      wr_status_ff <= wr_status_in;
      base_ff      <= base_in;
      diff_ff      <= diff_in;
      prod_ff      <= prod_in;
      coord_ff     <= coord_in;
      lower_ff     <= lower_in;
      found_ff     <= found_in;
      skip_ff      <= skip_in;
      rem_ff       <= rem_in;
      den_ff       <= den_in;
      quot_ff      <= quot_in;
      res_ff       <= res_in;
      rsp_ff       <= rsp_in;
   end

   assign status.item_op   = op_ff;
   assign status.scan_hit  = (coord_ff <= rd_value);
   assign status.scan_last = (rd_addr_ff == LAST_ADDR);
   assign rsp_payload      = rsp_ff;

endmodule

`default_nettype wire

@@ rtl/core/brc_control.sv @@
`timescale 1ns / 1ps
`default_nettype none

module brc_control (
   input  wire logic                           clock,
   input  wire logic                           reset,
   input  wire logic                           req_valid,
   output logic                                req_ready,
   input  wire logic [brc_pkg::CMD_W-1:0]      req_op,
   output logic                                rsp_valid,
   input  wire logic                           rsp_ready,
   output brc_pkg::brc_dp_cmd_type             cmd,
   input  wire brc_pkg::brc_dp_status_type     status
);
   import brc_pkg::*;

   localparam int STATE_W = 4;
   localparam logic [STATE_W-1:0] S_IDLE   = STATE_W'(0);
   localparam logic [STATE_W-1:0] S_WRITE  = STATE_W'(1);
   localparam logic [STATE_W-1:0] S_RD_A   = STATE_W'(2);
   localparam logic [STATE_W-1:0] S_RD_B   = STATE_W'(3);
   localparam logic [STATE_W-1:0] S_DIFF   = STATE_W'(4);
   localparam logic [STATE_W-1:0] S_MUL    = STATE_W'(5);
   localparam logic [STATE_W-1:0] S_CLAMP  = STATE_W'(6);
   localparam logic [STATE_W-1:0] S_SCAN   = STATE_W'(7);
   localparam logic [STATE_W-1:0] S_DIV    = STATE_W'(8);
   localparam logic [STATE_W-1:0] S_RESULT = STATE_W'(9);
   localparam logic [STATE_W-1:0] S_FINISH = STATE_W'(10);

   logic [STATE_W-1:0]   state_ff, state_in;
   logic [DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;
   logic                 rsp_valid_ff, rsp_valid_in;
   logic                 inverse;

   assign inverse = (status.item_op == OP_TO_BRIGHT);

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load_item = 1'b1;
               state_in      = (req_op == OP_WRITE) ? S_WRITE : S_RD_A;
            end
         end
         S_WRITE: begin
            cmd.do_write = 1'b1;
            state_in     = S_RESULT;
         end
         S_RD_A: begin
            cmd.rd_en  = 1'b1;
            cmd.rd_sel = inverse ? RD_SEL_FIRST : RD_SEL_LOWER;
            state_in   = S_RD_B;
         end
         S_RD_B: begin
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = inverse ? RD_SEL_LAST : RD_SEL_UPPER;
            cmd.cap_base = 1'b1;
            state_in     = inverse ? S_CLAMP : S_DIFF;
         end
         S_DIFF: begin
            cmd.do_diff = 1'b1;
            state_in    = S_MUL;
         end
         S_MUL: begin
            cmd.do_mul = 1'b1;
            state_in   = S_RESULT;
         end
         S_CLAMP: begin
            cmd.do_clamp = 1'b1;
            cmd.rd_en    = 1'b1;
            cmd.rd_sel   = RD_SEL_ONE;
            state_in     = S_SCAN;
         end
         S_SCAN: begin
            cmd.scan_step = 1'b1;
            if (status.scan_hit) begin
               div_cnt_in = DIV_CNT_W'(QUOT_W - 1);
               state_in   = S_DIV;
            end else if (status.scan_last) begin
               state_in = S_RESULT;
            end else begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = RD_SEL_NEXT;
            end
         end
         S_DIV: begin
            cmd.div_step = 1'b1;
            if (div_cnt_ff == '0) begin
               state_in = S_RESULT;
            end else begin
               div_cnt_in = div_cnt_ff - 1'b1;
            end
         end
         S_RESULT: begin
            cmd.do_result = 1'b1;
            state_in      = S_FINISH;
         end
         S_FINISH: begin
            // wait for the output register to free up
            if (!rsp_valid_ff || rsp_ready) begin
               cmd.load_rsp = 1'b1;
               state_in     = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
      rsp_valid_in = cmd.load_rsp | (rsp_valid_ff & ~rsp_ready);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      div_cnt_ff <= div_cnt_in;
   end

   assign req_ready = (state_ff == S_IDLE);
   assign rsp_valid = rsp_valid_ff;

`ifndef ASSERT_OFF
   a_reset_idle: assert property (@(posedge clock)
      reset |=> (state_ff == S_IDLE && !rsp_valid_ff))
      else $error("controller not idle after reset");

   a_accept_leaves_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready) |=> (state_ff != S_IDLE))
      else $error("accepted beat did not start work");

   a_rsp_from_finish: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid_ff) |-> ($past(state_ff) == S_FINISH))
      else $error("result beat raised outside finish");

   a_div_inverse_only: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_DIV) |-> (status.item_op == OP_TO_BRIGHT))
      else $error("division running for a non-inverse item");
`endif

endmodule

`default_nettype wire

@@ rtl/core/brightness_response_curve.sv @@
// Brightness response curve: holds a 101-point monotone curve in unsigned
// Q7.16 (identity after reset, calibrated flag clear) and answers one request
// beat with exactly one response beat. Command 0 writes a curve entry into the
// shadow bank; entries must arrive in order from 0, entry 0 must be zero and
// each step must lie in [0.05, 1.0], else the load is dropped (status 1) and
// the live curve stays. Writing the last entry swaps banks, sets calibrated and
// returns status 2. Command 1 maps brightness to a coordinate by clamped
// linear interpolation, command 2 maps a coordinate back to brightness, and
// command 3 returns the local slope. Commands 1 and 3 read the two end points
// of the segment and take their difference; command 2 walks the curve entries
// through the single registered curve read port until the containing segment
// is found, then runs a bit-serial fraction divider. One item is in work at a
// time; the response sits in an output register, so the next request beat is
// taken while it waits, at the earliest on the edge after response valid rises.
`timescale 1ns / 1ps
`default_nettype none

module brightness_response_curve (
   input  wire logic                  clock,
   input  wire logic                  reset,
   input  wire logic                  req_valid,
   output logic                       req_ready,
   input  wire brc_pkg::brc_req_type  req_payload,
   output logic                       rsp_valid,
   input  wire logic                  rsp_ready,
   output brc_pkg::brc_rsp_type       rsp_payload
);
   import brc_pkg::*;

   brc_dp_cmd_type    dp_cmd;
   brc_dp_status_type dp_status;

   // sequencing: accept, curve reads, segment scan, divide, respond
   brc_control u_control (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .req_op    (req_payload.command),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .cmd       (dp_cmd),
      .status    (dp_status)
   );

   // curve banks, load checks, interpolation and division
   brc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (dp_cmd),
      .status      (dp_status),
      .req_payload (req_payload),
      .rsp_payload (rsp_payload)
   );

endmodule

`default_nettype wire
